// ----- rtl/rdsm_pkg.sv -----
// ----------------------------------------------------------------------------
// rdsm_pkg
// Shared item codes, special byte values and default sizing for the
// dot-star pattern matcher.
// ----------------------------------------------------------------------------
package rdsm_pkg;

  // default number of pattern tokens held in the store
  localparam int unsigned PATTERN_MAX_DEF = 16;

  // special pattern bytes
  localparam logic [7:0] STAR_BYTE = 8'h2A;
  localparam logic [7:0] ANY_BYTE  = 8'h2E;
  localparam logic [7:0] NUL_BYTE  = 8'h00;

  // input item kinds
  typedef enum logic [1:0] {
    KIND_APPEND  = 2'd0,
    KIND_SUBJECT = 2'd1,
    KIND_END     = 2'd2,
    KIND_CLEAR   = 2'd3
  } kind_t;

endpackage

// ----- rtl/rdsm_closure.sv -----
// ----------------------------------------------------------------------------
// rdsm_closure
// Epsilon closure over starred tokens: an active position whose token is
// starred also activates the next position. Built as a log-depth prefix
// network so the whole chain settles in a few gate levels.
// ----------------------------------------------------------------------------
module rdsm_closure
  import rdsm_pkg::*;
#(
  parameter int unsigned PATTERN_MAX = PATTERN_MAX_DEF
) (
  input  logic [PATTERN_MAX:0]   set_in,
  input  logic [PATTERN_MAX-1:0] starred,
  output logic [PATTERN_MAX:0]   set_out
);

  localparam int unsigned POS_W = PATTERN_MAX + 1;
  localparam int unsigned LVL   = $clog2(POS_W);

  // per level generate / propagate vectors
  logic [POS_W-1:0] gen_v  [LVL+1];
  logic [POS_W-1:0] prop_v [LVL+1];

  // propagate into position k comes from the token at k-1
  assign gen_v[0]  = set_in;
  assign prop_v[0] = {starred, 1'b0};

  // prefix levels, span doubles each level
  for (genvar d = 0; d < LVL; d++) begin : g_lvl
    for (genvar k = 0; k < POS_W; k++) begin : g_pos
      if (k >= (1 << d)) begin : g_mrg
        assign gen_v[d+1][k]  = gen_v[d][k] | (prop_v[d][k] & gen_v[d][k-(1<<d)]);
        assign prop_v[d+1][k] = prop_v[d][k] & prop_v[d][k-(1<<d)];
      end else begin : g_cpy
        assign gen_v[d+1][k]  = gen_v[d][k];
        assign prop_v[d+1][k] = prop_v[d][k];
      end
    end
  end

  assign set_out = gen_v[LVL];

endmodule

// ----- rtl/rdsm_pattern_store.sv -----
// ----------------------------------------------------------------------------
// rdsm_pattern_store
// Token store: token bytes, star flags, token count and overflow flag.
// Also keeps the closed start vector (position zero plus its closure).
// ----------------------------------------------------------------------------
module rdsm_pattern_store
  import rdsm_pkg::*;
#(
  parameter int unsigned PATTERN_MAX = PATTERN_MAX_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               item_en,
  input  kind_t                              item_kind,
  input  logic [7:0]                         item_byte,
  output logic [PATTERN_MAX-1:0][7:0]        tok_char,
  output logic [PATTERN_MAX-1:0]             tok_starred,
  output logic [$clog2(PATTERN_MAX+1)-1:0]   tok_count,
  output logic                               overflow,
  output logic [PATTERN_MAX:0]               start_set
);

  localparam int unsigned CNT_W = $clog2(PATTERN_MAX + 1);

  logic [PATTERN_MAX-1:0][7:0] char_r;
  logic [PATTERN_MAX-1:0]      starred_r, starred_nxt;
  logic [CNT_W-1:0]            cnt_r, cnt_nxt;
  logic                        ovf_r, ovf_nxt;
  logic [PATTERN_MAX:0]        start_r, start_nxt;
  logic                        last_open;
  logic                        chr_we;

  // last token exists and is not yet starred
  always_comb begin
    last_open = 1'b0;
    for (int i = 0; i < PATTERN_MAX; i++) begin
      if (cnt_r == CNT_W'(i + 1) && !starred_r[i]) begin
        last_open = 1'b1;
      end
    end
  end

  // next store state
  always_comb begin
    starred_nxt = starred_r;
    cnt_nxt     = cnt_r;
    ovf_nxt     = ovf_r;
    chr_we      = 1'b0;
    if (item_en) begin
      unique case (item_kind)
        KIND_APPEND: begin
          if (item_byte != NUL_BYTE) begin
            if (item_byte == STAR_BYTE && last_open) begin
              for (int i = 0; i < PATTERN_MAX; i++) begin
                if (cnt_r == CNT_W'(i + 1)) begin
                  starred_nxt[i] = 1'b1;
                end
              end
            end else if (cnt_r < CNT_W'(PATTERN_MAX)) begin
              chr_we  = 1'b1;
              cnt_nxt = cnt_r + CNT_W'(1);
            end else begin
              ovf_nxt = 1'b1;
            end
          end
        end
        KIND_CLEAR: begin
          starred_nxt = '0;
          cnt_nxt     = '0;
          ovf_nxt     = 1'b0;
        end
        KIND_SUBJECT, KIND_END: begin
        end
        default: begin
        end
      endcase
    end
  end

  // closure of position zero under the next star flags
  rdsm_closure #(
    .PATTERN_MAX (PATTERN_MAX)
  ) u_start_cl (
    .set_in  ((PATTERN_MAX+1)'(1)),
    .starred (starred_nxt),
    .set_out (start_nxt)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      starred_r <= '0;
      cnt_r     <= '0;
      ovf_r     <= 1'b0;
      start_r   <= (PATTERN_MAX+1)'(1);
    end else begin
      starred_r <= starred_nxt;
      cnt_r     <= cnt_nxt;
      ovf_r     <= ovf_nxt;
      start_r   <= start_nxt;
    end
  end

  // token bytes, written at the current count
  always_ff @(posedge clk) begin
    for (int i = 0; i < PATTERN_MAX; i++) begin
      if (chr_we && cnt_r == CNT_W'(i)) begin
        char_r[i] <= item_byte;
      end
    end
  end

  assign tok_char    = char_r;
  assign tok_starred = starred_r;
  assign tok_count   = cnt_r;
  assign overflow    = ovf_r;
  assign start_set   = start_r;

endmodule

// ----- rtl/rdsm_nfa.sv -----
// ----------------------------------------------------------------------------
// rdsm_nfa
// Active position vector. Steps one subject byte per cycle while item_en is high
// and reports the whole-string match at end of subject.
// ----------------------------------------------------------------------------
module rdsm_nfa
  import rdsm_pkg::*;
#(
  parameter int unsigned PATTERN_MAX = PATTERN_MAX_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               item_en,
  input  kind_t                              item_kind,
  input  logic [7:0]                         item_byte,
  input  logic [PATTERN_MAX-1:0][7:0]        tok_char,
  input  logic [PATTERN_MAX-1:0]             tok_starred,
  input  logic [$clog2(PATTERN_MAX+1)-1:0]   tok_count,
  input  logic [PATTERN_MAX:0]               start_set,
  output logic                               hit
);

  localparam int unsigned CNT_W = $clog2(PATTERN_MAX + 1);

  logic                 armed_r, armed_nxt;
  logic [PATTERN_MAX:0] act_r, act_nxt;
  logic [PATTERN_MAX:0] cur;
  logic [PATTERN_MAX:0] step_set;
  logic [PATTERN_MAX:0] step_closed;

  // closed set of live positions; rearmed means position zero closure
  assign cur = armed_r ? start_set : act_r;

  // byte match, consume or loop on starred tokens
  always_comb begin
    step_set = '0;
    for (int i = 0; i < PATTERN_MAX; i++) begin
      if (cur[i] && CNT_W'(i) < tok_count &&
          (tok_char[i] == ANY_BYTE || tok_char[i] == item_byte)) begin
        if (tok_starred[i]) begin
          step_set[i] = 1'b1;
        end else begin
          step_set[i+1] = 1'b1;
        end
      end
    end
  end

  rdsm_closure #(
    .PATTERN_MAX (PATTERN_MAX)
  ) u_step_cl (
    .set_in  (step_set),
    .starred (tok_starred),
    .set_out (step_closed)
  );

  // final position live
  always_comb begin
    hit = 1'b0;
    for (int i = 0; i <= PATTERN_MAX; i++) begin
      if (tok_count == CNT_W'(i) && cur[i]) begin
        hit = 1'b1;
      end
    end
  end

  // next active state
  always_comb begin
    armed_nxt = armed_r;
    act_nxt   = act_r;
    if (item_en) begin
      unique case (item_kind)
        KIND_APPEND: begin
          if (item_byte != NUL_BYTE) begin
            armed_nxt = 1'b1;
          end
        end
        KIND_SUBJECT: begin
          if (item_byte != NUL_BYTE) begin
            armed_nxt = 1'b0;
            act_nxt   = step_closed;
          end
        end
        KIND_END, KIND_CLEAR: begin
          armed_nxt = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r <= 1'b1;
      act_r   <= (PATTERN_MAX+1)'(1);
    end else begin
      armed_r <= armed_nxt;
      act_r   <= act_nxt;
    end
  end

endmodule

// ----- rtl/regex_dot_star_matcher_unit.sv -----
// Results pass the input register, then the result register. Throughput: one
// item per cycle unless a stalled output holds the pipe; the byte step is one
// pass through the match compare and prefix closure network between them.
// Reset (synchronous, rst_n low): empty pattern, no overflow, position zero live,
// no result pending. Token bytes are not cleared.
// ----------------------------------------------------------------------------
// regex_dot_star_matcher_unit
// Whole-string matcher for literal, '.' and '*' patterns. Pattern bytes build
// the token store, subject bytes step the NFA, end of subject gives a result.
// ----------------------------------------------------------------------------
module regex_dot_star_matcher_unit
  import rdsm_pkg::*;
#(
  parameter int unsigned PATTERN_MAX = PATTERN_MAX_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_kind,
  input  logic [7:0] in_byte_value,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_matched,
  output logic       out_pattern_overflow
);

  localparam int unsigned CNT_W = $clog2(PATTERN_MAX + 1);

  logic                        adv;
  logic                        s_valid_r;
  kind_t                       s_kind_r;
  logic [7:0]                  s_byte_r;
  logic                        item_en;
  logic                        out_valid_r;
  logic                        out_matched_r;
  logic                        out_ovf_r;
  logic [PATTERN_MAX-1:0][7:0] tok_char;
  logic [PATTERN_MAX-1:0]      tok_starred;
  logic [CNT_W-1:0]            tok_count;
  logic                        overflow;
  logic [PATTERN_MAX:0]        start_set;
  logic                        hit;

  // whole pipe moves unless a result waits on a stalled output
  assign adv      = !(out_valid_r && out_stall);
  assign in_stall = !adv;
  assign item_en  = adv && s_valid_r;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r <= 1'b0;
    end else if (adv) begin
      s_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_valid) begin
      s_kind_r <= kind_t'(in_kind);
      s_byte_r <= in_byte_value;
    end
  end

  rdsm_pattern_store #(
    .PATTERN_MAX (PATTERN_MAX)
  ) u_store (
    .clk         (clk),
    .rst_n       (rst_n),
    .item_en     (item_en),
    .item_kind   (s_kind_r),
    .item_byte   (s_byte_r),
    .tok_char    (tok_char),
    .tok_starred (tok_starred),
    .tok_count   (tok_count),
    .overflow    (overflow),
    .start_set   (start_set)
  );

  rdsm_nfa #(
    .PATTERN_MAX (PATTERN_MAX)
  ) u_nfa (
    .clk         (clk),
    .rst_n       (rst_n),
    .item_en     (item_en),
    .item_kind   (s_kind_r),
    .item_byte   (s_byte_r),
    .tok_char    (tok_char),
    .tok_starred (tok_starred),
    .tok_count   (tok_count),
    .start_set   (start_set),
    .hit         (hit)
  );

  // result register, loaded on end of subject
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s_valid_r && (s_kind_r == KIND_END);
    end
  end

  always_ff @(posedge clk) begin
    if (item_en && s_kind_r == KIND_END) begin
      out_matched_r <= hit && !overflow;
      out_ovf_r     <= overflow;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_matched          = out_matched_r;
  assign out_pattern_overflow = out_ovf_r;

endmodule
